// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for concurrent checks on a synchronous, active-high reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// jse_pkg
// types, character codes and the hold-buffer step of the jis converter
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

   localparam int MAX_RESULTS = 9;

   localparam logic [7:0] CH_ESC    = 8'h1b;
   localparam logic [7:0] CH_SO     = 8'h0e;
   localparam logic [7:0] CH_SI     = 8'h0f;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_BSL    = 8'h5c;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_PAREN  = 8'h28;
   localparam logic [7:0] CH_KANA_I = 8'h49;
   localparam logic [7:0] CH_ZERO   = 8'h30;

   localparam logic [2:0] MODE_KANA  = 3'b001;
   localparam logic [2:0] MODE_KANJI = 3'b010;
   localparam logic [2:0] MODE_JKANA = 3'b100;

   localparam logic [1:0] DES_NONE   = 2'd0;
   localparam logic [1:0] DES_DOLLAR = 2'd1;
   localparam logic [1:0] DES_PAREN  = 2'd2;

   localparam logic [1:0] CSR_TARGET_CODE      = 2'd0;
   localparam logic [1:0] CSR_OCTAL_HIGH_BYTES = 2'd1;
   localparam logic [1:0] CSR_DOUBLE_BACKSLASH = 2'd2;
   localparam logic [1:0] CSR_DROP_BACKSPACE   = 2'd3;

   typedef struct packed {
      logic target_code;
      logic octal_high_bytes;
      logic double_backslash;
      logic drop_backspace;
   } cfg_type;

   // raw: put the low byte as is; otherwise convert hi/lo (hi zero for kana)
   typedef struct packed {
      logic       valid;
      logic       raw;
      logic [7:0] hi;
      logic [7:0] lo;
   } job_type;

   typedef struct packed {
      job_type job1;
      job_type job2;
   } entry_type;

   typedef struct packed {
      logic [1:0] count;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [2:0] mode;
   } held_type;

   typedef struct packed {
      held_type held;
      job_type  job;
   } hold_result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic [1:0] held_count;
   } front_status_type;

   typedef struct packed {
      logic [3:0] remaining;
   } back_status_type;

   typedef struct packed {
      logic [3:0][7:0] b;
      logic [2:0]      n;
   } piece_type;

   typedef struct packed {
      logic [8:0][7:0] bytes;
      logic [3:0]      n;
   } exp_type;

   // one step of the hold buffer: flush what may go, then hold the new byte
   function automatic hold_result_type hold_byte(held_type h, logic has, logic [7:0] b,
                                                 logic [2:0] sm);
      hold_result_type r;
      r.held = h;
      r.job  = '0;
      if (h.count == 2'd2) begin
         r.job.valid  = 1'b1;
         r.job.hi     = h.b0;
         r.job.lo     = h.b1;
         r.held.count = 2'd0;
      end else if (h.count == 2'd1) begin
         if ((h.mode & (MODE_KANA | MODE_JKANA)) != 3'b000) begin
            r.job.valid  = 1'b1;
            r.job.lo     = h.b0;
            r.held.count = 2'd0;
         end else if ((h.mode & MODE_KANJI) == 3'b000) begin
            r.job.valid  = 1'b1;
            r.job.raw    = 1'b1;
            r.job.lo     = h.b0;
            r.held.count = 2'd0;
         end
      end
      r.held.mode = sm;
      if (has && r.held.count < 2'd2) begin
         if (r.held.count == 2'd0) begin
            r.held.b0 = b;
         end else begin
            r.held.b1 = b;
         end
         r.held.count = r.held.count + 2'd1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jse_front.sv =====
// ----------------------------------------------------------------------------
// jse_front
// escape/shift tracking and byte holding; emits up to two conversion jobs
// ----------------------------------------------------------------------------
`default_nettype none

module jse_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic [7:0]                in_byte,
   input  wire logic                      in_eos,
   input  wire logic                      drop_bs,
   input  wire jse_pkg::fifo_status_type  fifo_stat,
   output logic                           push,
   output jse_pkg::entry_type             push_entry,
   output jse_pkg::front_status_type      stat
);

   logic [2:0]        shift_ff, shift_in;
   logic              esc_ff, esc_in;
   logic [1:0]        des_ff, des_in;
   jse_pkg::held_type held_ff, held_in;

   logic              accept;
   logic              rel;
   logic              clr;
   logic              q1_en, q1_has, q2_en;
   logic [7:0]        q1_b, q2_b;

   jse_pkg::hold_result_type r1, r2;

   assign in_ready = !fifo_stat.full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      shift_in = shift_ff;
      esc_in   = esc_ff;
      des_in   = des_ff;
      rel      = 1'b0;
      clr      = 1'b0;
      q1_en    = 1'b0;
      q1_has   = 1'b1;
      q1_b     = in_byte;
      q2_en    = 1'b0;
      q2_b     = jse_pkg::CH_DOLLAR;
      if (in_eos) begin
         q1_en  = 1'b1;
         q1_has = 1'b0;
      end else if (in_byte == jse_pkg::CH_ESC) begin
         rel    = 1'b1;
         esc_in = 1'b1;
         des_in = jse_pkg::DES_NONE;
      end else if (in_byte == jse_pkg::CH_DOLLAR || in_byte == jse_pkg::CH_PAREN) begin
         if (!esc_ff) begin
            q1_en = (des_ff == jse_pkg::DES_NONE);
         end else begin
            shift_in = shift_ff & ~jse_pkg::MODE_JKANA;
            esc_in   = 1'b0;
            des_in   = (in_byte == jse_pkg::CH_DOLLAR) ? jse_pkg::DES_DOLLAR
                                                       : jse_pkg::DES_PAREN;
         end
      end else if (in_byte == jse_pkg::CH_SO || in_byte == jse_pkg::CH_SI) begin
         rel      = 1'b1;
         shift_in = (in_byte == jse_pkg::CH_SO) ? (shift_ff | jse_pkg::MODE_KANA)
                                                : (shift_ff & ~jse_pkg::MODE_KANA);
         esc_in   = 1'b0;
         des_in   = jse_pkg::DES_NONE;
      end else if (in_byte == jse_pkg::CH_BS && drop_bs) begin
         rel    = 1'b1;
         clr    = 1'b1;
         esc_in = 1'b0;
         des_in = jse_pkg::DES_NONE;
      end else begin
         if (esc_ff) begin
            q1_en = 1'b1;
            q1_b  = jse_pkg::CH_ESC;
         end else if (des_ff == jse_pkg::DES_DOLLAR) begin
            shift_in = shift_ff | jse_pkg::MODE_KANJI;
         end else if (des_ff == jse_pkg::DES_PAREN) begin
            shift_in = (in_byte == jse_pkg::CH_KANA_I) ? (shift_ff | jse_pkg::MODE_JKANA)
                                                       : (shift_ff & ~jse_pkg::MODE_KANJI);
         end else begin
            q1_en = 1'b1;
         end
         esc_in = 1'b0;
         des_in = jse_pkg::DES_NONE;
      end
      // cut-short escape or designator goes out as data
      if (rel) begin
         if (esc_ff) begin
            q1_en = 1'b1;
            q1_b  = jse_pkg::CH_ESC;
         end else if (des_ff != jse_pkg::DES_NONE) begin
            q1_en = 1'b1;
            q1_b  = jse_pkg::CH_ESC;
            q2_en = 1'b1;
            q2_b  = (des_ff == jse_pkg::DES_DOLLAR) ? jse_pkg::CH_DOLLAR : jse_pkg::CH_PAREN;
         end
      end
   end

   always_comb begin
      if (q1_en) begin
         r1 = jse_pkg::hold_byte(held_ff, q1_has, q1_b, shift_ff);
      end else begin
         r1.held = held_ff;
         r1.job  = '0;
      end
      if (q2_en) begin
         r2 = jse_pkg::hold_byte(r1.held, 1'b1, q2_b, shift_ff);
      end else begin
         r2.held = r1.held;
         r2.job  = '0;
      end
      held_in = r2.held;
      if (clr) begin
         held_in.count = 2'd0;
         held_in.mode  = 3'b000;
      end
   end

   assign push            = accept && (r1.job.valid || r2.job.valid);
   assign push_entry.job1 = r1.job;
   assign push_entry.job2 = r2.job;
   assign stat.held_count = held_ff.count;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff      <= 3'b000;
         esc_ff        <= 1'b0;
         des_ff        <= jse_pkg::DES_NONE;
         held_ff.count <= 2'd0;
         held_ff.mode  <= 3'b000;
      end else if (accept) begin
         shift_ff <= shift_in;
         esc_ff   <= esc_in;
         des_ff   <= des_in;
         held_ff  <= held_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/jse_fifo.sv =====
// ----------------------------------------------------------------------------
// jse_fifo
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module jse_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire jse_pkg::entry_type       push_entry,
   input  wire logic                     pop,
   output jse_pkg::entry_type            pop_entry,
   output jse_pkg::fifo_status_type      stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   jse_pkg::entry_type entries_ff [DEPTH];
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               do_push, do_pop;

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_entry  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/jse_back.sv =====
// ----------------------------------------------------------------------------
// jse_back
// code conversion of queued jobs and byte-wise output serialiser
// ----------------------------------------------------------------------------
`default_nettype none

module jse_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire jse_pkg::cfg_type         cfg,
   input  wire jse_pkg::fifo_status_type fifo_stat,
   input  wire jse_pkg::entry_type       pop_entry,
   output logic                          pop,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [7:0]                    out_byte,
   output logic                          out_last,
   output jse_pkg::back_status_type      stat
);

   function automatic jse_pkg::piece_type code_piece(logic [8:0] v, logic octal);
      jse_pkg::piece_type p;
      p = '0;
      if (octal && v[7]) begin
         p.b[0] = jse_pkg::CH_BSL;
         p.b[1] = jse_pkg::CH_ZERO | {5'b00000, v[8:6]};
         p.b[2] = jse_pkg::CH_ZERO | {5'b00000, v[5:3]};
         p.b[3] = jse_pkg::CH_ZERO | {5'b00000, v[2:0]};
         p.n    = 3'd4;
      end else begin
         p.b[0] = v[7:0];
         p.n    = 3'd1;
      end
      return p;
   endfunction

   function automatic jse_pkg::exp_type expand(jse_pkg::job_type j, jse_pkg::cfg_type c);
      logic [8:0]         a;
      logic [8:0]         b;
      logic [7:0]         hm1;
      logic [8:0]         boff;
      logic [8:0]         abase;
      logic               nx;
      logic               plain;
      logic [3:0]         na, nab, pp, q;
      jse_pkg::piece_type pa, pb;
      jse_pkg::exp_type   e;
      e     = '0;
      a     = '0;
      b     = '0;
      pa    = '0;
      pb    = '0;
      nx    = 1'b0;
      hm1   = j.hi - 8'd1;
      plain = (j.lo <= 8'h20) || (j.lo >= 8'h60);
      abase = (j.hi < 8'h5f) ? 9'h071 : 9'h0b1;
      boff  = j.hi[0] ? ((j.lo < 8'h60) ? 9'h01f : 9'h020) : 9'h07e;
      if (j.valid) begin
         if (j.raw) begin
            pa = code_piece({1'b0, j.lo}, c.octal_high_bytes);
         end else begin
            if (c.target_code) begin
               if (j.hi != 8'h00) begin
                  a = {1'b0, j.hi | 8'h80};
                  b = {1'b0, j.lo | 8'h80};
               end else if (plain) begin
                  b = {1'b0, j.lo};
               end else begin
                  a = 9'h08e;
                  b = {1'b0, j.lo | 8'h80};
               end
            end else begin
               if (j.hi != 8'h00) begin
                  a = {2'b00, hm1[7:1]} + abase;
                  b = {1'b0, j.lo} + boff;
               end else if (plain) begin
                  b = {1'b0, j.lo};
               end else begin
                  b = {1'b0, j.lo | 8'h80};
               end
            end
            if (a != 9'h000) begin
               pa = code_piece(a, c.octal_high_bytes);
            end
            if (b != 9'h000) begin
               pb = code_piece(b, c.octal_high_bytes);
            end
            nx = (b == {1'b0, jse_pkg::CH_BSL}) && (c.double_backslash || c.octal_high_bytes);
         end
         na  = {1'b0, pa.n};
         nab = na + {1'b0, pb.n};
         for (int p = 0; p < 9; p++) begin
            pp = 4'(p);
            q  = pp - na;
            if (pp < na) begin
               e.bytes[p] = pa.b[pp[1:0]];
            end else if (pp < nab) begin
               e.bytes[p] = pb.b[q[1:0]];
            end else begin
               e.bytes[p] = jse_pkg::CH_BSL;
            end
         end
         e.n = nab + {3'b000, nx};
      end
      return e;
   endfunction

   logic             exp_valid_ff, exp_valid_in;
   jse_pkg::exp_type exp1_ff, exp2_ff;
   logic [8:0][7:0]  ser_bytes_ff, ser_bytes_in;
   logic [3:0]       ser_cnt_ff, ser_cnt_in;
   logic             ser_free, ser_load, exp_free, xfer;
   logic [4:0]       total;
   logic [3:0]       pp, q;

   assign xfer      = out_valid && out_ready;
   assign ser_free  = (ser_cnt_ff == 4'd0) || ((ser_cnt_ff == 4'd1) && out_ready);
   assign ser_load  = exp_valid_ff && ser_free;
   assign exp_free  = !exp_valid_ff || ser_load;
   assign pop       = !fifo_stat.empty && exp_free;
   assign out_valid = (ser_cnt_ff != 4'd0);
   assign out_byte  = ser_bytes_ff[0];
   assign out_last  = (ser_cnt_ff == 4'd1);
   assign stat.remaining = ser_cnt_ff;

   assign exp_valid_in = pop ? 1'b1 : (ser_load ? 1'b0 : exp_valid_ff);
   assign total        = {1'b0, exp1_ff.n} + {1'b0, exp2_ff.n};

   always_comb begin
      ser_bytes_in = ser_bytes_ff;
      ser_cnt_in   = ser_cnt_ff;
      pp           = '0;
      q            = '0;
      if (ser_load) begin
         for (int p = 0; p < 9; p++) begin
            pp = 4'(p);
            q  = pp - exp1_ff.n;
            if (pp < exp1_ff.n) begin
               ser_bytes_in[p] = exp1_ff.bytes[pp];
            end else begin
               ser_bytes_in[p] = exp2_ff.bytes[q];
            end
         end
         ser_cnt_in = (total > 5'(jse_pkg::MAX_RESULTS)) ? 4'(jse_pkg::MAX_RESULTS)
                                                         : total[3:0];
      end else if (xfer) begin
         ser_bytes_in = {8'h00, ser_bytes_ff[8:1]};
         ser_cnt_in   = ser_cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_valid_ff <= 1'b0;
         ser_cnt_ff   <= 4'd0;
      end else begin
         exp_valid_ff <= exp_valid_in;
         ser_cnt_ff   <= ser_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ser_bytes_ff <= ser_bytes_in;
      if (pop) begin
         exp1_ff <= expand(pop_entry.job1, cfg);
         exp2_ff <= expand(pop_entry.job2, cfg);
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/jis_to_sjis_euc_converter.sv =====
// path: an input's jobs pass the job queue, the expand registers and the output serialiser
// throughput: one input byte per cycle into the front while the job queue is not full;
//   the output serialiser moves one byte per cycle while rsp_tready is high, n = 0..9 per input
// the job queue absorbs bursts between the two sides
// reset: synchronous; clears shift, escape and hold state, configuration to 0
// ----------------------------------------------------------------------------
// jis_to_sjis_euc_converter
// iso-2022-jp byte stream to shift-jis or euc-jp conversion, top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jis_to_sjis_euc_converter #(
   parameter int FIFO_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tuser,   // [0] end_of_stream
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic       csr_wdata
);

   jse_pkg::cfg_type          cfg_ff, cfg_in;
   jse_pkg::fifo_status_type  fifo_stat;
   jse_pkg::front_status_type front_stat;
   jse_pkg::back_status_type  back_stat;
   jse_pkg::entry_type        push_entry, pop_entry;
   logic                      push, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            jse_pkg::CSR_TARGET_CODE:      cfg_in.target_code      = csr_wdata;
            jse_pkg::CSR_OCTAL_HIGH_BYTES: cfg_in.octal_high_bytes = csr_wdata;
            jse_pkg::CSR_DOUBLE_BACKSLASH: cfg_in.double_backslash = csr_wdata;
            jse_pkg::CSR_DROP_BACKSPACE:   cfg_in.drop_backspace   = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   jse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_eos     (req_tuser),
      .drop_bs    (cfg_ff.drop_backspace),
      .fifo_stat  (fifo_stat),
      .push       (push),
      .push_entry (push_entry),
      .stat       (front_stat)
   );

   jse_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .stat       (fifo_stat)
   );

   jse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fifo_stat (fifo_stat),
      .pop_entry (pop_entry),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast),
      .stat      (back_stat)
   );

   `ASSERT_SAME(a_no_push_full, clock, reset, push, !fifo_stat.full, "job pushed into full queue")
   `ASSERT_SAME(a_held_bound, clock, reset, 1'b1, front_stat.held_count != 2'd3, "hold overflow")
   `ASSERT_SAME(a_rsp_bound, clock, reset, rsp_tvalid,
                back_stat.remaining <= 4'(jse_pkg::MAX_RESULTS), "too many results")
   `ASSERT_NEXT(a_pop_nonempty, clock, reset, pop && !push && fifo_stat.full, !fifo_stat.full,
                "queue not drained on pop")

endmodule

`default_nettype wire
